### rtl/lzwe_pkg.sv
// constants shared by the lzw byte encoder
package lzwe_pkg;

  localparam int CODE_BITS_DEF = 15;
  localparam int HASH_BITS_DEF = 16;
  localparam int CODE_W        = 15;
  localparam int LIMIT_W       = 17;
  localparam int EPOCH_BITS    = 8;

  localparam logic [CODE_W-1:0] LIMIT_RESET = 15'd32767;
  localparam int                CLEAR_CODE  = 256;
  localparam int                FIRST_FREE  = 257;
  localparam logic [31:0]       HASH_MULT   = 32'h9E37_79B1;

endpackage

### rtl/lzw_byte_encoder_with_clear.sv
// lzw byte encoder with dictionary clear, hashed dictionary in one synchronous memory
//
//   channel | dir | handshake           | payload
//   s_      | in  | s_tvalid / s_tready | s_tdata = data_byte, s_tlast = end_of_stream
//   m_      | out | m_tvalid / m_tready | m_tdata = code, m_tuser = last_of_item,
//           |     |                     | m_tlast = stream_done
//   cfg_    | in  | cfg_valid/cfg_ready | cfg_data = code_limit
//
// a byte with a live prefix passes S_HASH, then S_READ and S_CMP for each dictionary probe,
// then S_EMIT for each emitted code; the probe loop runs over the single memory port
// a byte that starts a prefix is taken in S_IDLE, then S_EMIT runs for each emitted code
// after reset, and after every 255th dictionary clear, a wipe of all 2^HASH_BITS slots runs
// while s_tready is low; cfg writes are taken at all times
// a finished code sits in the output register while the next byte is taken
module lzw_byte_encoder_with_clear #(
  parameter int CODE_BITS = lzwe_pkg::CODE_BITS_DEF,
  parameter int HASH_BITS = lzwe_pkg::HASH_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lzwe_pkg::CODE_W-1:0] cfg_data,   // code_limit
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,      // data_byte
  input  logic                      s_tlast,      // end_of_stream
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [15:0]               m_tdata,      // code, zero pad
  output logic                      m_tuser,      // last_of_item
  output logic                      m_tlast       // stream_done
);
  import lzwe_pkg::*;

  localparam int KEY_W      = CODE_BITS + 8;
  localparam int ENTRY_W    = EPOCH_BITS + KEY_W + CODE_BITS;
  localparam int SLOT_COUNT = 1 << HASH_BITS;

  typedef enum logic [5:0] {
    S_WIPE = 6'b000001,
    S_IDLE = 6'b000010,
    S_HASH = 6'b000100,
    S_READ = 6'b001000,
    S_CMP  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t                 state;
  logic [CODE_W-1:0]      code_limit;
  logic [CODE_BITS-1:0]   prefix_code;
  logic [CODE_BITS:0]     next_free_code;
  logic                   prefix_valid;
  logic                   clear_pending;
  logic [EPOCH_BITS-1:0]  epoch;
  logic                   wipe_req;
  logic [HASH_BITS-1:0]   wipe_addr;
  logic [KEY_W-1:0]       key;
  logic                   eos;
  logic [31:0]            prod;
  logic [HASH_BITS-1:0]   addr;
  logic [HASH_BITS-1:0]   probe_cnt;
  logic [CODE_BITS-1:0]   q_code0;
  logic [CODE_BITS-1:0]   q_code1;
  logic [1:0]             q_n;
  logic                   q_idx;

  logic [ENTRY_W-1:0]     dict_mem [SLOT_COUNT];
  logic [ENTRY_W-1:0]     rd_q;
  logic                   mem_we;
  logic [HASH_BITS-1:0]   mem_waddr;
  logic [ENTRY_W-1:0]     mem_wdata;

  logic [EPOCH_BITS-1:0]  rd_epoch;
  logic [KEY_W-1:0]       rd_key;
  logic [CODE_BITS-1:0]   rd_code;
  logic                   slot_live;
  logic                   hit;
  logic                   full;
  logic                   resolve;
  logic [CODE_BITS-1:0]   p1;
  logic [CODE_BITS:0]     nx1;
  logic                   flush;
  logic [EPOCH_BITS-1:0]  epoch_next;
  logic                   out_load;
  logic [CODE_BITS-1:0]   out_code;
  logic                   out_last;

  assign rd_epoch  = rd_q[ENTRY_W-1 -: EPOCH_BITS];
  assign rd_key    = rd_q[CODE_BITS +: KEY_W];
  assign rd_code   = rd_q[CODE_BITS-1:0];
  assign slot_live = (rd_epoch == epoch);
  assign hit       = slot_live && (rd_key == key);
  assign full      = slot_live && !hit && (&probe_cnt);
  assign resolve   = !slot_live || hit || full;
  assign p1        = hit ? rd_code : CODE_BITS'(key[7:0]);
  assign nx1       = hit ? next_free_code : next_free_code + 1'b1;
  assign flush     = (LIMIT_W'(nx1) >= LIMIT_W'(code_limit)) || nx1[CODE_BITS];
  assign epoch_next = epoch + 1'b1;

  assign mem_we    = (state == S_WIPE) || (state == S_CMP && !slot_live);
  assign mem_waddr = (state == S_WIPE) ? wipe_addr : addr;
  assign mem_wdata = (state == S_WIPE) ? '0
                                       : {epoch, key, next_free_code[CODE_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dict_mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= dict_mem[addr];
  end

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign out_load  = (state == S_EMIT) && (!m_tvalid || m_tready);
  assign out_code  = q_idx ? q_code1 : q_code0;
  assign out_last  = (2'(q_idx) + 2'd1 == q_n);

  always_ff @(posedge clk) begin
    if (rst) begin
      code_limit <= LIMIT_RESET;
    end else if (cfg_valid) begin
      code_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_WIPE;
      wipe_addr      <= '0;
      wipe_req       <= 1'b0;
      epoch          <= '0;
      prefix_code    <= '0;
      next_free_code <= (CODE_BITS+1)'(FIRST_FREE);
      prefix_valid   <= 1'b0;
      clear_pending  <= 1'b0;
      q_n            <= '0;
      q_idx          <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tdata  <= 16'(CODE_W'(out_code));
        m_tuser  <= out_last;
        m_tlast  <= out_last && eos;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_WIPE: begin
          wipe_addr <= wipe_addr + 1'b1;
          if (&wipe_addr) begin
            epoch    <= EPOCH_BITS'(1);
            wipe_req <= 1'b0;
            state    <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            key   <= {prefix_code, s_tdata};
            eos   <= s_tlast;
            q_idx <= 1'b0;
            prod  <= 32'(KEY_W'({prefix_code, s_tdata})) * HASH_MULT;
            if (!prefix_valid) begin
              q_code0 <= clear_pending ? CODE_BITS'(CLEAR_CODE) : CODE_BITS'(s_tdata);
              q_code1 <= CODE_BITS'(s_tdata);
              q_n     <= 2'(clear_pending) + 2'(s_tlast);
              clear_pending <= 1'b0;
              if (s_tlast) begin
                prefix_code  <= '0;
                prefix_valid <= 1'b0;
              end else begin
                prefix_code  <= CODE_BITS'(s_tdata);
                prefix_valid <= 1'b1;
              end
              if (clear_pending || s_tlast) begin
                state <= S_EMIT;
              end
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          addr      <= prod[31 -: HASH_BITS];
          probe_cnt <= '0;
          state     <= S_READ;
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (!resolve) begin
            addr      <= addr + 1'b1;
            probe_cnt <= probe_cnt + 1'b1;
            state     <= S_READ;
          end else begin
            q_code0 <= hit ? p1 : prefix_code;
            q_code1 <= p1;
            q_n     <= 2'(!hit) + 2'(flush || eos);
            if (flush || eos) begin
              next_free_code <= (CODE_BITS+1)'(FIRST_FREE);
              prefix_valid   <= 1'b0;
              clear_pending  <= flush && !eos;
              prefix_code    <= eos ? '0 : p1;
              epoch          <= epoch_next;
              wipe_req       <= (epoch_next == '0);
            end else begin
              prefix_code    <= p1;
              next_free_code <= nx1;
            end
            if (!hit || flush || eos) begin
              state <= S_EMIT;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_EMIT: begin
          if (out_load) begin
            q_idx <= 1'b1;
            if (out_last) begin
              wipe_addr <= '0;
              state     <= wipe_req ? S_WIPE : S_IDLE;
            end
          end
        end
        default: begin
          state <= S_WIPE;
        end
      endcase
    end
  end

  a_next_floor: assert property (@(posedge clk) disable iff (rst)
    next_free_code >= (CODE_BITS+1)'(FIRST_FREE))
    else $error("next free code below first free code");

  a_wipe_no_prefix: assert property (@(posedge clk) disable iff (rst)
    state == S_WIPE |-> !prefix_valid)
    else $error("dictionary wipe with a live prefix");

  a_insert_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP && mem_we) |-> rd_epoch != epoch)
    else $error("insert over a live slot");

  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (q_n != 2'd0) && (2'(q_idx) < q_n))
    else $error("code emitted beyond the queued count");

  a_probe_after_hash: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> $past(state) == S_READ)
    else $error("compare without a preceding memory read");

endmodule

### test/lzw_byte_encoder_with_clear_tb.sv
// testbench for the lzw byte encoder: directed table, then random streams checked by a predictor
module lzw_byte_encoder_with_clear_tb;
  import lzwe_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_WAIT  = 60;
  localparam int LONG_HOLD   = 400;
  localparam int NO_CFG      = -1;
  localparam int NO_EXP      = -1;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic              last_of_item;
    logic              stream_done;
  } code_word_t;

  typedef struct {
    int       cfg_limit;
    bit [7:0] data_byte;
    bit       eos;
    int       first_code;
  } stim_row_t;

  logic              clk;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CODE_W-1:0] cfg_data;
  logic              s_tvalid;
  logic              s_tready;
  logic [7:0]        s_tdata;
  logic              s_tlast;
  logic              m_tvalid;
  logic              m_tready;
  logic [15:0]       m_tdata;
  logic              m_tuser;
  logic              m_tlast;

  code_word_t  code_q[$];
  int unsigned dict_code[int unsigned];
  int unsigned prefix_code;
  int unsigned next_code;
  int unsigned code_limit;
  bit          prefix_valid;
  bit          clear_due;
  int          first_pred;

  int  errors;
  int  items_sent;
  int  codes_seen;
  int  clears_seen;
  int  cycles;
  bit  gaps_on;
  bit  hold_req;

  lzw_byte_encoder_with_clear i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void encoder_reset_state();
    dict_code.delete();
    prefix_code  = 0;
    next_code    = FIRST_FREE;
    prefix_valid = 1'b0;
    clear_due    = 1'b0;
  endfunction

  // works out the codes one byte causes and queues them
  function automatic void predict_codes(bit [7:0] b, bit eos);
    int unsigned codes[$];
    int unsigned key;
    int unsigned lim;
    code_word_t  w;
    lim = (code_limit > 32768) ? 32768 : code_limit;
    if (!prefix_valid) begin
      if (clear_due) codes.push_back(CLEAR_CODE);
      clear_due    = 1'b0;
      prefix_code  = b;
      prefix_valid = 1'b1;
      if (eos) codes.push_back(prefix_code);
    end else begin
      key = ((prefix_code & 32'hFFFF) << 8) | b;
      if (dict_code.exists(key)) begin
        prefix_code = dict_code[key];
      end else begin
        codes.push_back(prefix_code);
        dict_code[key] = next_code;
        next_code      = (next_code + 1) & 32'hFFFF;
        prefix_code    = b;
      end
      if (next_code >= lim) begin
        codes.push_back(prefix_code);
        dict_code.delete();
        next_code    = FIRST_FREE;
        prefix_valid = 1'b0;
        clear_due    = !eos;
      end else if (eos) begin
        codes.push_back(prefix_code);
      end
    end
    if (eos) encoder_reset_state();
    first_pred = (codes.size() != 0) ? int'(codes[0]) : NO_EXP;
    foreach (codes[k]) begin
      w.code         = codes[k][CODE_W-1:0];
      w.last_of_item = (k == codes.size() - 1);
      w.stream_done  = w.last_of_item && eos;
      code_q.push_back(w);
    end
  endfunction

  task automatic send_byte(bit [7:0] b, bit eos);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eos;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_codes(b, eos);
    items_sent++;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (code_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_limit(int unsigned v);
    cfg_valid <= 1'b1;
    cfg_data  <= v[CODE_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    code_limit = v & 32'h7FFF;
    @(posedge clk);
  endtask

  // random streams; narrow alphabets build long dictionary chains
  task automatic run_phase(int unsigned lim, int n_items, bit wide);
    int       sent;
    int       len;
    bit [7:0] b;
    drain();
    write_limit(lim);
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (code_q.size() != 0) @(posedge clk);
      end
      for (int i = 0; i < len; i++) begin
        if (wide || $urandom_range(0, 9) == 0) b = $urandom_range(0, 255);
        else b = 8'd60 + $urandom_range(0, 2);
        send_byte(b, i == len - 1);
      end
      sent += len;
    end
  endtask

  stim_row_t dir_rows[] = '{
    '{NO_CFG, 8'd255, 1'b1, 255},
    '{NO_CFG, 8'd0,   1'b1, 0},
    '{258,    8'd65,  1'b0, NO_EXP},
    '{NO_CFG, 8'd66,  1'b0, 65},
    '{NO_CFG, 8'd67,  1'b0, CLEAR_CODE},
    '{NO_CFG, 8'd68,  1'b0, 67},
    '{NO_CFG, 8'd69,  1'b1, CLEAR_CODE},
    '{NO_CFG, 8'd70,  1'b0, NO_EXP},
    '{NO_CFG, 8'd71,  1'b1, 70},
    '{32767,  8'd1,   1'b0, NO_EXP},
    '{NO_CFG, 8'd2,   1'b0, 1},
    '{NO_CFG, 8'd1,   1'b0, 2},
    '{NO_CFG, 8'd2,   1'b0, NO_EXP},
    '{NO_CFG, 8'd1,   1'b0, 257},
    '{NO_CFG, 8'd2,   1'b0, NO_EXP},
    '{258,    8'd1,   1'b0, 259},
    '{NO_CFG, 8'd3,   1'b1, CLEAR_CODE},
    '{32767,  8'd128, 1'b0, NO_EXP},
    '{NO_CFG, 8'd127, 1'b1, 128}
  };

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    code_word_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (code_q.size() == 0) begin
        $error("code word 0x%0h with nothing expected", m_tdata);
        errors++;
      end else begin
        w = code_q.pop_front();
        codes_seen++;
        if (w.code == CLEAR_CODE) clears_seen++;
        if (m_tdata !== {1'b0, w.code}) begin
          $error("code: expected %0d, got %0d", w.code, m_tdata);
          errors++;
        end
        if (m_tuser !== w.last_of_item) begin
          $error("last_of_item: expected %0b, got %0b", w.last_of_item, m_tuser);
          errors++;
        end
        if (m_tlast !== w.stream_done) begin
          $error("stream_done: expected %0b, got %0b", w.stream_done, m_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    errors    = 0;
    cycles    = 0;
    gaps_on   = 1'b0;
    hold_req  = 1'b0;
    first_pred = NO_EXP;
    code_limit = LIMIT_RESET;
    encoder_reset_state();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].cfg_limit != NO_CFG) begin
        drain();
        write_limit(dir_rows[r].cfg_limit);
      end
      send_byte(dir_rows[r].data_byte, dir_rows[r].eos);
      if (dir_rows[r].first_code != NO_EXP && first_pred != dir_rows[r].first_code) begin
        $error("code: expected %0d first for table row %0d, got %0d",
               dir_rows[r].first_code, r, first_pred);
        errors++;
      end
    end

    gaps_on = 1'b1;
    run_phase(32767, 100, 1'b0);
    hold_req = 1'b1;
    run_phase(258, 100, 1'b0);
    run_phase(259, 90, 1'b1);
    run_phase(300, 100, 1'b0);
    run_phase($urandom_range(258, 1000), 100, 1'b0);
    run_phase(600, 100, 1'b1);
    gaps_on = 1'b0;
    run_phase(32767, 100, 1'b0);
    drain();

    $display("covered %0d bytes, %0d codes checked, %0d clear markers", items_sent,
             codes_seen, clears_seen);
    $display("limits from 258 to 32767, short and long streams, long output stall");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/lzwe_pkg.sv
rtl/lzw_byte_encoder_with_clear.sv
test/lzw_byte_encoder_with_clear_tb.sv
